// ----- hw/rtl/delta_list_event_timer_queue_defines.svh -----
// Assertion macros for the delta-list event timer queue.
// Taken in by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DELTA_LIST_EVENT_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_EVENT_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define DLETQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define DLETQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dletq_pkg.sv -----
// Shared types, codes and helpers for the delta-list event timer queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package dletq_pkg;

  // Default sizing, handed down from the top level
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_OWNER_BITS  = 8;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int DATA_W   = 32;
  localparam int TAG_W    = 32;
  localparam int DELTA_W  = 32;
  localparam int DELAY_W  = 31;
  localparam int TICK_W   = 20;
  localparam int ENTRY_FIXED_W = DATA_W + TAG_W + DELTA_W;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  // Result kinds
  localparam logic RES_FIRED = 1'b0;
  localparam logic RES_FULL  = 1'b1;

  // Saturation bounds of a stored delay
  localparam int SAT_IN_W = 64;
  localparam logic signed [SAT_IN_W-1:0] DELTA_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [SAT_IN_W-1:0] DELTA_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_HEAD,
    ST_TICK_EVAL,
    ST_WALK,
    ST_FINISH,
    ST_RESULT
  } dletq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic issue;
    logic walk;
    logic head_eval;
    logic finish;
    logic load_out;
  } dletq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic more;
    logic dv;
    logic head_due;
    logic res_pend;
    logic out_free;
  } dletq_stat_t;

  // Clamp a wide signed value to the signed 32-bit delay range
  function automatic logic signed [DELTA_W-1:0] sat_delta(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic signed [DELTA_W-1:0] r;
    if (v > DELTA_MAX) begin
      r = DELTA_MAX[DELTA_W-1:0];
    end else if (v < DELTA_MIN) begin
      r = DELTA_MIN[DELTA_W-1:0];
    end else begin
      r = v[DELTA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dletq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on dletq_pkg for default sizing only.
`default_nettype none

module dletq_ram
  import dletq_pkg::*;
#(
  parameter int WIDTH = DEF_OWNER_BITS + ENTRY_FIXED_W,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dletq_ctrl.sv -----
// Controller state machine of the delta-list event timer queue.
// Depends on dletq_pkg and the assertion macros header; drives the datapath commands.
`default_nettype none
`include "delta_list_event_timer_queue_defines.svh"

module dletq_ctrl
  import dletq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  input  wire logic [ACTION_W-1:0] action,
  output logic                     item_ready,
  input  wire dletq_stat_t         st,
  output dletq_cmd_t               cmd
);

  dletq_state_t state;
  dletq_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (action)
            ACT_TICK:   state_next = st.empty ? ST_IDLE : ST_TICK_HEAD;
            ACT_ADD:    state_next = st.full ? ST_RESULT : ST_WALK;
            ACT_REMOVE: state_next = ST_WALK;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_TICK_HEAD: state_next = ST_TICK_EVAL;
      ST_TICK_EVAL: state_next = st.head_due ? ST_WALK : ST_IDLE;
      ST_WALK: begin
        if (!st.more && !st.dv) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = st.res_pend ? ST_RESULT : ST_IDLE;
      ST_RESULT: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.start  = item_valid;
      end
      ST_TICK_HEAD: cmd.issue = 1'b1;
      ST_TICK_EVAL: cmd.head_eval = 1'b1;
      ST_WALK: begin
        cmd.walk  = 1'b1;
        cmd.issue = st.more;
      end
      ST_FINISH: cmd.finish = 1'b1;
      ST_RESULT: cmd.load_out = st.out_free;
      default: cmd = '0;
    endcase
  end

  // Consistency of the walk and the result hand-off
  `DLETQ_ASSERT_IMP(a_issue_in_range, clk, rst, cmd.issue, st.more, "read issued past the last entry")
  `DLETQ_ASSERT_IMP(a_finish_drained, clk, rst, cmd.finish, !st.dv, "finish with a read still in flight")
  `DLETQ_ASSERT_IMP(a_eval_has_data, clk, rst, state == ST_TICK_EVAL, st.dv, "head evaluated without read data")
  `DLETQ_ASSERT_IMP(a_result_pending, clk, rst, state == ST_RESULT, st.res_pend, "result state with nothing to deliver")
  `DLETQ_ASSERT_NXT(a_full_rejects, clk, rst, item_valid && item_ready && action == ACT_ADD && st.full, st.res_pend, "add on a full queue raised no rejection")

endmodule

`default_nettype wire

// ----- hw/rtl/dletq_dp.sv -----
// Datapath of the delta-list event timer queue: entry RAM, walk pointers, delay arithmetic.
// Depends on dletq_pkg and dletq_ram; steered by dletq_ctrl through command and status structs.
`default_nettype none

module dletq_dp
  import dletq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int OWNER_BITS  = DEF_OWNER_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dletq_cmd_t            cmd,
  output dletq_stat_t                st,
  input  wire logic [ACTION_W-1:0]   action,
  input  wire logic [OWNER_BITS-1:0] owner_id,
  input  wire logic [DATA_W-1:0]     event_data,
  input  wire logic [TAG_W-1:0]      event_tag,
  input  wire logic [DELAY_W-1:0]    delay_us,
  input  wire logic [TICK_W-1:0]     tick_us,
  input  wire logic                  result_ready,
  output logic                       result_valid,
  output logic                       result_kind,
  output logic [OWNER_BITS-1:0]      fired_owner,
  output logic [DATA_W-1:0]          fired_data,
  output logic [TAG_W-1:0]           fired_tag
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = OWNER_BITS + ENTRY_FIXED_W;
  // Running sums of up to QUEUE_DEPTH signed delays
  localparam int CW      = DELTA_W + IDX_W + 1;

  // Control registers
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] w_ptr;
  logic             dv;
  logic             ins;
  logic             res_pend;

  // Item and walk registers
  logic [ACTION_W-1:0]       act_q;
  logic [OWNER_BITS-1:0]     owner_q;
  logic [DATA_W-1:0]         data_q;
  logic [TAG_W-1:0]          tag_q;
  logic [DELAY_W-1:0]        delay_q;
  logic [TICK_W-1:0]         tick_q;
  logic [IDX_W-1:0]          rd_idx;
  logic signed [CW-1:0]      cum;
  logic signed [CW-1:0]      carry;
  logic signed [DELTA_W-1:0] dreg;
  logic [ENTRY_W-1:0]        pending;
  logic                      fire_kind;
  logic [OWNER_BITS-1:0]     fire_owner;
  logic [DATA_W-1:0]         fire_data;
  logic [TAG_W-1:0]          fire_tag;

  // RAM port signals
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;

  // Fields of the entry being read
  logic [OWNER_BITS-1:0]     r_owner;
  logic [DATA_W-1:0]         r_data;
  logic [TAG_W-1:0]          r_tag;
  logic signed [DELTA_W-1:0] r_delta;

  // Extended operands and results
  logic signed [CW:0]        delta_x;
  logic signed [CW:0]        tick_x;
  logic signed [CW:0]        delay_x;
  logic signed [CW:0]        cum_x;
  logic signed [CW:0]        carry_x;
  logic signed [CW:0]        dreg_x;
  logic signed [CW:0]        nd_x;
  logic signed [CW:0]        new_sum;
  logic signed [CW:0]        carry_sum;
  logic signed [DELTA_W-1:0] head_d;
  logic signed [DELTA_W-1:0] nd;
  logic signed [DELTA_W-1:0] split_delta;
  logic signed [DELTA_W-1:0] rem_delta;
  logic signed [DELTA_W-1:0] shift_delta;
  logic                      lt;
  logic                      match;
  logic                      full;
  logic                      walk_dv;

  dletq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.issue),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Unpack the read entry
  assign r_owner = rdata[ENTRY_W-1 -: OWNER_BITS];
  assign r_data  = rdata[DELTA_W+TAG_W+DATA_W-1 -: DATA_W];
  assign r_tag   = rdata[DELTA_W+TAG_W-1 -: TAG_W];
  assign r_delta = signed'(rdata[DELTA_W-1:0]);

  // Widen every operand to the running-sum width
  assign delta_x = (CW+1)'(r_delta);
  assign tick_x  = signed'((CW+1)'(tick_q));
  assign delay_x = signed'((CW+1)'(delay_q));
  assign cum_x   = (CW+1)'(cum);
  assign carry_x = (CW+1)'(carry);
  assign dreg_x  = (CW+1)'(dreg);
  assign nd_x    = (CW+1)'(nd);

  // Head after the elapsed time
  assign head_d = sat_delta(SAT_IN_W'(delta_x - tick_x));

  // Insertion search: new event goes before the first entry due strictly later
  assign new_sum     = cum_x + delta_x;
  assign lt          = delay_x < new_sum;
  assign nd          = sat_delta(SAT_IN_W'(delay_x - cum_x));
  assign split_delta = sat_delta(SAT_IN_W'(delta_x - nd_x));

  // Removal: fold removed delays into the next kept entry
  assign carry_sum = carry_x + delta_x;
  assign rem_delta = sat_delta(SAT_IN_W'(delta_x + carry_x));
  assign match     = (r_owner == owner_q);

  // Shift down after a fire: the new head takes the overrun
  assign shift_delta = (rd_idx == IDX_W'(1)) ? sat_delta(SAT_IN_W'(delta_x + dreg_x)) : r_delta;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign walk_dv = cmd.walk && dv;

  // Single RAM write per cycle
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.head_eval && !(head_d[DELTA_W-1] || head_d == '0)) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {r_owner, r_data, r_tag, head_d};
    end else if (walk_dv) begin
      case (act_q)
        ACT_TICK: begin
          we    = 1'b1;
          waddr = rd_idx - IDX_W'(1);
          wdata = {r_owner, r_data, r_tag, shift_delta};
        end
        ACT_ADD: begin
          if (ins) begin
            we    = 1'b1;
            waddr = rd_idx;
            wdata = pending;
          end else if (lt) begin
            we    = 1'b1;
            waddr = rd_idx;
            wdata = {owner_q, data_q, tag_q, nd};
          end
        end
        ACT_REMOVE: begin
          if (!match) begin
            we    = 1'b1;
            waddr = w_ptr[IDX_W-1:0];
            wdata = {r_owner, r_data, r_tag, rem_delta};
          end
        end
        default: we = 1'b0;
      endcase
    end else if (cmd.finish && act_q == ACT_ADD) begin
      we    = 1'b1;
      waddr = count[IDX_W-1:0];
      wdata = ins ? pending : {owner_q, data_q, tag_q, nd};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      rd_ptr       <= '0;
      w_ptr        <= '0;
      dv           <= 1'b0;
      ins          <= 1'b0;
      res_pend     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      dv <= cmd.issue;
      if (cmd.start) begin
        rd_ptr <= '0;
        w_ptr  <= '0;
        ins    <= 1'b0;
      end else if (cmd.issue) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
      if (walk_dv && act_q == ACT_ADD && !ins && lt) begin
        ins <= 1'b1;
      end
      if (walk_dv && act_q == ACT_REMOVE && !match) begin
        w_ptr <= w_ptr + CNT_W'(1);
      end
      // Commit the new fill level
      if (cmd.finish) begin
        case (act_q)
          ACT_ADD:    count <= count + CNT_W'(1);
          ACT_TICK:   count <= count - CNT_W'(1);
          ACT_REMOVE: count <= w_ptr;
          default:    count <= count;
        endcase
      end
      // Track a result waiting for the output register
      if (cmd.start && action == ACT_ADD && full) begin
        res_pend <= 1'b1;
      end else if (cmd.head_eval && (head_d[DELTA_W-1] || head_d == '0)) begin
        res_pend <= 1'b1;
      end else if (cmd.load_out) begin
        res_pend <= 1'b0;
      end
      // Output register: hold until the transaction completes
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_idx <= rd_ptr[IDX_W-1:0];
    end
    if (cmd.start) begin
      act_q   <= action;
      owner_q <= owner_id;
      data_q  <= event_data;
      tag_q   <= event_tag;
      delay_q <= delay_us;
      tick_q  <= tick_us;
      cum     <= '0;
      carry   <= '0;
      if (action == ACT_ADD && full) begin
        fire_kind  <= RES_FULL;
        fire_owner <= owner_id;
        fire_data  <= event_data;
        fire_tag   <= event_tag;
      end
    end
    // Capture the head and its overrun
    if (cmd.head_eval) begin
      dreg       <= head_d;
      fire_kind  <= RES_FIRED;
      fire_owner <= r_owner;
      fire_data  <= r_data;
      fire_tag   <= r_tag;
    end
    if (walk_dv) begin
      case (act_q)
        ACT_ADD: begin
          if (ins) begin
            pending <= rdata;
          end else if (lt) begin
            pending <= {r_owner, r_data, r_tag, split_delta};
          end else begin
            cum <= new_sum[CW-1:0];
          end
        end
        ACT_REMOVE: begin
          if (match) begin
            carry <= carry_sum[CW-1:0];
          end else begin
            carry <= '0;
          end
        end
        default: cum <= cum;
      endcase
    end
    if (cmd.load_out) begin
      result_kind <= fire_kind;
      fired_owner <= fire_owner;
      fired_data  <= fire_data;
      fired_tag   <= fire_tag;
    end
  end

  // Status to the controller
  always_comb begin
    st          = '0;
    st.empty    = (count == '0);
    st.full     = full;
    st.more     = (rd_ptr < count);
    st.dv       = dv;
    st.head_due = head_d[DELTA_W-1] || (head_d == '0);
    st.res_pend = res_pend;
    st.out_free = !result_valid || result_ready;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/delta_list_event_timer_queue.sv -----
// Channel   | signals                          | payload
// ----------+----------------------------------+----------------------------------------
// item      | item_valid, item_ready           | action, owner_id, event_data, event_tag,
//           |                                  | delay_us, tick_us
// result    | result_valid, result_ready       | result_kind, fired_owner, fired_data,
//           |                                  | fired_tag
//
// One item at a time. Add, remove and a firing tick walk the queued entries, reading
// one entry per cycle through the single read port of the entry RAM; a tick that
// leaves the head pending reads the head only, and an add on a full queue answers
// without a walk. Reset is synchronous and clears the control registers only (fill
// count, pointers, flags); the entry RAM needs no clearing pass. The output register
// lets the next item be taken while a result waits; an item with its own result then
// holds at its end until the previous transaction on the result channel completes.
// Top level; depends on dletq_pkg, dletq_ctrl, dletq_dp and dletq_ram.
`default_nettype none

module delta_list_event_timer_queue
  import dletq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int OWNER_BITS  = DEF_OWNER_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire logic [ACTION_W-1:0]   action,
  input  wire logic [OWNER_BITS-1:0] owner_id,
  input  wire logic [DATA_W-1:0]     event_data,
  input  wire logic [TAG_W-1:0]      event_tag,
  input  wire logic [DELAY_W-1:0]    delay_us,
  input  wire logic [TICK_W-1:0]     tick_us,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic                       result_kind,
  output logic [OWNER_BITS-1:0]      fired_owner,
  output logic [DATA_W-1:0]          fired_data,
  output logic [TAG_W-1:0]           fired_tag
);

  dletq_cmd_t  cmd;
  dletq_stat_t st;

  dletq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .action     (action),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  dletq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .OWNER_BITS  (OWNER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .action       (action),
    .owner_id     (owner_id),
    .event_data   (event_data),
    .event_tag    (event_tag),
    .delay_us     (delay_us),
    .tick_us      (tick_us),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .fired_owner  (fired_owner),
    .fired_data   (fired_data),
    .fired_tag    (fired_tag)
  );

endmodule

`default_nettype wire
